// ===== rtl/vlsu_pkg.sv =====
// Shared constants for the versioned letter stack: field widths, command
// and status codes, parameter defaults. No dependencies.
package vlsu_pkg;

	localparam int MAX_COMMANDS_DEF  = 1024;
	localparam int ALPHABET_SIZE_DEF = 26;

	localparam int OP_W     = 2;
	localparam int LETTER_W = 5;
	localparam int UNDO_W   = 11;
	localparam int POS_W    = 10;
	localparam int LEN_W    = 11;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_TYPE = 2'd0;
	localparam logic [OP_W-1:0] OP_UNDO = 2'd1;
	localparam logic [OP_W-1:0] OP_GET  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNDO_FAR  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_POS_RANGE = 2'd3;

endpackage

// ===== rtl/vlsu_if.sv =====
// Valid/ready channel interfaces for commands and results.
// Depends on vlsu_pkg for the field widths.
interface vlsu_cmd_if;
	import vlsu_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [LETTER_W-1:0] letter_in;
	logic [UNDO_W-1:0]   undo_count;
	logic [POS_W-1:0]    position;

	modport source (output valid, op, letter_in, undo_count, position, input ready);
	modport sink   (input valid, op, letter_in, undo_count, position, output ready);
endinterface

interface vlsu_rsp_if;
	import vlsu_pkg::*;
	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] letter_out;
	logic [LEN_W-1:0]    text_length;
	logic [STATUS_W-1:0] status;

	modport source (output valid, letter_out, text_length, status, input ready);
	modport sink   (input valid, letter_out, text_length, status, output ready);
endinterface

// ===== rtl/vlsu_node_ram.sv =====
// Node store: letter, parent reference and depth of every typed node.
// One write port, one read port with registered data. Uses vlsu_pkg.
module vlsu_node_ram #(
	parameter int MAX_COMMANDS = vlsu_pkg::MAX_COMMANDS_DEF,
	localparam int NW = $clog2(MAX_COMMANDS)
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [NW-1:0]                 wr_addr,
	input  logic [vlsu_pkg::LETTER_W-1:0] wr_letter,
	input  logic                          wr_par_vld,
	input  logic [NW-1:0]                 wr_par,
	input  logic [NW-1:0]                 wr_depth,
	input  logic                          rd_en,
	input  logic [NW-1:0]                 rd_addr,
	output logic [vlsu_pkg::LETTER_W-1:0] rd_letter,
	output logic                          rd_par_vld,
	output logic [NW-1:0]                 rd_par,
	output logic [NW-1:0]                 rd_depth
);
	import vlsu_pkg::*;

	localparam int EW = LETTER_W + 1 + 2 * NW;

	logic [EW-1:0] mem [MAX_COMMANDS];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_letter, wr_par_vld, wr_par, wr_depth};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign {rd_letter, rd_par_vld, rd_par, rd_depth} = rd_q;

endmodule

// ===== rtl/vlsu_hist_ram.sv =====
// Version history: the node that stood current after each command
// (flag clear means empty text). Registered read. Uses vlsu_pkg.
module vlsu_hist_ram #(
	parameter int MAX_COMMANDS = vlsu_pkg::MAX_COMMANDS_DEF,
	localparam int NW = $clog2(MAX_COMMANDS)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [NW-1:0] wr_addr,
	input  logic          wr_vld,
	input  logic [NW-1:0] wr_node,
	input  logic          rd_en,
	input  logic [NW-1:0] rd_addr,
	output logic          rd_vld,
	output logic [NW-1:0] rd_node
);
	import vlsu_pkg::*;

	logic [NW:0] mem [MAX_COMMANDS];
	logic [NW:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_vld, wr_node};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign {rd_vld, rd_node} = rd_q;

endmodule

// ===== rtl/versioned_letter_stack_undo.sv =====
// Versioned letter stack with undo: command sequencer over the node store
// and the version history. Depends on vlsu_pkg, vlsu_if, vlsu_node_ram,
// vlsu_hist_ram.
//
// Usage:
//   cmd carries one command per transfer (type, undo, get); rsp returns
//   exactly one result per command: letter, text length after it, status.
//   Commands are taken one at a time; cmd.ready is high while the
//   sequencer is idle, also while a finished result still waits in the
//   output register.
//   Steps from transfer to result loaded:
//     type                 node and history write at transfer
//     undo                 history step; then, unless the text is
//                          restored to empty, depth read of the restored node
//     get                  one node read per letter walked, from the
//                          end of the text back to the position
//     error or no-op       only the check at transfer
//   Reset clears the counters and makes the text empty; the memories are
//   not cleared, no entry is read before it is written.
//   If rsp stalls, a finished result holds in the sequencer until the
//   output register frees up; a further command is then not taken.
module versioned_letter_stack_undo #(
	parameter int MAX_COMMANDS  = vlsu_pkg::MAX_COMMANDS_DEF,
	parameter int ALPHABET_SIZE = vlsu_pkg::ALPHABET_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	vlsu_cmd_if.sink   cmd,
	vlsu_rsp_if.source rsp
);
	import vlsu_pkg::*;

	localparam int NW = $clog2(MAX_COMMANDS);
	localparam int CW = $clog2(MAX_COMMANDS + 1);
	localparam int EW = (CW > UNDO_W) ? CW : UNDO_W;
	localparam int PW = (NW > POS_W) ? NW : POS_W;
	localparam logic [CW-1:0] MaxCount = CW'(MAX_COMMANDS);
	localparam logic [LETTER_W-1:0] SatLetter =
		(ALPHABET_SIZE > 32) ? {LETTER_W{1'b1}} : LETTER_W'(ALPHABET_SIZE - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_HIST  = 5'b00010,
		ST_DEPTH = 5'b00100,
		ST_WALK  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       cmd_cnt_q, cmd_cnt_d;
	logic [CW-1:0]       node_cnt_q, node_cnt_d;
	logic                cur_vld_q, cur_vld_d;
	logic [NW-1:0]       cur_node_q, cur_node_d;
	logic [CW-1:0]       cur_len_q, cur_len_d;
	logic                use_hist_q, use_hist_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [LETTER_W-1:0] res_letter_q, res_letter_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;

	logic                rsp_vld_q;
	logic [LETTER_W-1:0] rsp_letter_q;
	logic [LEN_W-1:0]    rsp_len_q;
	logic [STATUS_W-1:0] rsp_status_q;

	logic                nd_wr_en, nd_rd_en;
	logic [NW-1:0]       nd_rd_addr;
	logic [LETTER_W-1:0] nd_wr_letter, nd_rd_letter;
	logic                nd_rd_par_vld;
	logic [NW-1:0]       nd_rd_par, nd_rd_depth;

	logic                hs_wr_en, hs_rd_en, hs_rd_vld, hs_wr_vld;
	logic [NW-1:0]       hs_wr_addr, hs_rd_addr, hs_rd_node;

	logic                fire, rsp_load;
	logic [EW-1:0]       ucount_ext, cmd_ext, len_ext, hist_idx;
	logic [PW-1:0]       pos_ext, depth_ext;

	assign fire       = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == ST_IDLE);
	assign rsp_load   = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);

	assign ucount_ext = EW'(cmd.undo_count);
	assign cmd_ext    = EW'(cmd_cnt_q);
	assign len_ext    = EW'(cur_len_q);
	assign hist_idx   = cmd_ext - ucount_ext - EW'(1);
	assign pos_ext    = PW'(pos_q);
	assign depth_ext  = PW'(nd_rd_depth);

	assign nd_wr_letter = (int'(cmd.letter_in) >= ALPHABET_SIZE) ? SatLetter : cmd.letter_in;
	assign hs_wr_vld    = use_hist_q && hs_rd_vld;
	assign hs_wr_addr   = cmd_cnt_q[NW-1:0];
	assign hs_rd_addr   = hist_idx[NW-1:0];

	always_comb begin
		state_d      = state_q;
		cmd_cnt_d    = cmd_cnt_q;
		node_cnt_d   = node_cnt_q;
		cur_vld_d    = cur_vld_q;
		cur_node_d   = cur_node_q;
		cur_len_d    = cur_len_q;
		use_hist_d   = use_hist_q;
		pos_d        = pos_q;
		res_letter_d = res_letter_q;
		res_status_d = res_status_q;
		nd_wr_en     = 1'b0;
		nd_rd_en     = 1'b0;
		nd_rd_addr   = cur_node_q;
		hs_wr_en     = 1'b0;
		hs_rd_en     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					res_letter_d = '0;
					res_status_d = STATUS_OK;
					state_d      = ST_DONE;
					priority case (cmd.op)
						OP_TYPE: begin
							if (node_cnt_q >= MaxCount || cmd_cnt_q >= MaxCount) begin
								res_status_d = STATUS_FULL;
							end else begin
								// node and history entries both land at the counts
								nd_wr_en   = 1'b1;
								hs_wr_en   = 1'b1;
								node_cnt_d = node_cnt_q + CW'(1);
								cmd_cnt_d  = cmd_cnt_q + CW'(1);
								cur_vld_d  = 1'b1;
								cur_node_d = node_cnt_q[NW-1:0];
								cur_len_d  = cur_len_q + CW'(1);
							end
						end
						OP_UNDO: begin
							if (cmd_cnt_q >= MaxCount) begin
								res_status_d = STATUS_FULL;
							end else if (ucount_ext > cmd_ext) begin
								res_status_d = STATUS_UNDO_FAR;
							end else begin
								use_hist_d = (ucount_ext < cmd_ext);
								hs_rd_en   = (ucount_ext < cmd_ext);
								state_d    = ST_HIST;
							end
						end
						OP_GET: begin
							if (EW'(cmd.position) >= len_ext) begin
								res_status_d = STATUS_POS_RANGE;
							end else begin
								pos_d    = cmd.position;
								nd_rd_en = 1'b1;
								state_d  = ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_HIST: begin
				// record the restored version as a command of its own
				hs_wr_en   = 1'b1;
				cmd_cnt_d  = cmd_cnt_q + CW'(1);
				cur_vld_d  = hs_wr_vld;
				cur_node_d = hs_rd_node;
				if (hs_wr_vld) begin
					nd_rd_en   = 1'b1;
					nd_rd_addr = hs_rd_node;
					state_d    = ST_DEPTH;
				end else begin
					cur_len_d = '0;
					state_d   = ST_DONE;
				end
			end
			ST_DEPTH: begin
				cur_len_d = CW'(nd_rd_depth) + CW'(1);
				state_d   = ST_DONE;
			end
			ST_WALK: begin
				if (depth_ext == pos_ext) begin
					res_letter_d = nd_rd_letter;
					state_d      = ST_DONE;
				end else if (!nd_rd_par_vld) begin
					state_d = ST_DONE;
				end else begin
					// advance to the parent
					nd_rd_en   = 1'b1;
					nd_rd_addr = nd_rd_par;
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_cnt_q  <= '0;
			node_cnt_q <= '0;
			cur_vld_q  <= 1'b0;
			cur_node_q <= '1;
			cur_len_q  <= '0;
			use_hist_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmd_cnt_q  <= cmd_cnt_d;
			node_cnt_q <= node_cnt_d;
			cur_vld_q  <= cur_vld_d;
			cur_node_q <= cur_node_d;
			cur_len_q  <= cur_len_d;
			use_hist_q <= use_hist_d;
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		res_letter_q <= res_letter_d;
		res_status_q <= res_status_d;
		if (rsp_load) begin
			rsp_letter_q <= res_letter_q;
			rsp_len_q    <= len_ext[LEN_W-1:0];
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.letter_out  = rsp_letter_q;
	assign rsp.text_length = rsp_len_q;
	assign rsp.status      = rsp_status_q;

	vlsu_node_ram #(
		.MAX_COMMANDS (MAX_COMMANDS)
	) u_node_ram (
		.clk        (clk),
		.wr_en      (nd_wr_en),
		.wr_addr    (node_cnt_q[NW-1:0]),
		.wr_letter  (nd_wr_letter),
		.wr_par_vld (cur_vld_q),
		.wr_par     (cur_node_q),
		.wr_depth   (cur_len_q[NW-1:0]),
		.rd_en      (nd_rd_en),
		.rd_addr    (nd_rd_addr),
		.rd_letter  (nd_rd_letter),
		.rd_par_vld (nd_rd_par_vld),
		.rd_par     (nd_rd_par),
		.rd_depth   (nd_rd_depth)
	);

	vlsu_hist_ram #(
		.MAX_COMMANDS (MAX_COMMANDS)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (hs_wr_en),
		.wr_addr (hs_wr_addr),
		.wr_vld  ((state_q == ST_IDLE) ? 1'b1 : hs_wr_vld),
		.wr_node ((state_q == ST_IDLE) ? node_cnt_q[NW-1:0] : hs_rd_node),
		.rd_en   (hs_rd_en),
		.rd_addr (hs_rd_addr),
		.rd_vld  (hs_rd_vld),
		.rd_node (hs_rd_node)
	);

endmodule
